FILE: src/mma_pkg.sv
// ----------------------------------------------------------------------------
// mma_pkg: shared types and constants for the matrix multiply-accumulate block
// Holds the beat formats, operation codes, register indexes, sequencer
// states and the control bundle between the sequencer and the MAC unit.
// ----------------------------------------------------------------------------
package mma_pkg;

    localparam int C_W     = 40;   // C elements, Q9.30
    localparam int SUM_W   = C_W + 1;
    localparam int ALIGN_W = 32;   // one product at 30 fraction bits
    localparam int DOT_W   = 36;   // up to 15 aligned products
    localparam int FRAC_C  = 30;
    localparam int DIM_W   = 4;
    localparam int CFG_W   = 4;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_A    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INNER_LEN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS_B    = 2'd2;

    localparam logic [2:0] OP_WR_A    = 3'd0;
    localparam logic [2:0] OP_WR_B    = 3'd1;
    localparam logic [2:0] OP_WR_C    = 3'd2;
    localparam logic [2:0] OP_COMPUTE = 3'd3;
    localparam logic [2:0] OP_READ_C  = 3'd4;

    localparam logic KIND_READ = 1'b0;
    localparam logic KIND_DONE = 1'b1;

    typedef struct packed {
        logic [2:0]            operation;
        logic [2:0]            row;
        logic [2:0]            col;
        logic signed [C_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic                  kind;
        logic signed [C_W-1:0] read_value;
        logic                  overflow;
    } t_out_item;

    typedef struct packed {
        logic [DIM_W-1:0] nr;
        logic [DIM_W-1:0] nk;
        logic [DIM_W-1:0] nc;
    } t_dims;

    typedef struct packed {
        logic clr;     // zero the dot-product accumulator
        logic mul_en;  // capture a product from the RAM outputs
        logic acc_en;  // add the aligned product
    } t_mac_ctrl;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_MAC,
        ST_DRAIN,
        ST_WB,
        ST_RESULT
    } t_state;

endpackage

FILE: src/mma_ram.sv
// ----------------------------------------------------------------------------
// mma_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module mma_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/mma_mac.sv
// ----------------------------------------------------------------------------
// mma_mac: shared multiply-accumulate unit
// Registered multiplier, alignment to 30 fraction bits, dot-product
// accumulator and the saturating add into a C element.
// ----------------------------------------------------------------------------
module mma_mac #(
    parameter int ELEM_WIDTH = 16
) (
    input  logic                          i_clk,
    input  mma_pkg::t_mac_ctrl            i_ctrl,
    input  logic signed [ELEM_WIDTH-1:0]  i_a,
    input  logic signed [ELEM_WIDTH-1:0]  i_b,
    input  logic signed [mma_pkg::C_W-1:0] i_c,
    output logic signed [mma_pkg::C_W-1:0] o_sum,
    output logic                          o_sat
);

    localparam int PW        = 2 * ELEM_WIDTH;
    localparam int PROD_FRAC = 2 * (ELEM_WIDTH - 1);
    localparam int SH_R = (PROD_FRAC >= mma_pkg::FRAC_C) ? PROD_FRAC - mma_pkg::FRAC_C : 0;
    localparam int SH_L = (PROD_FRAC <  mma_pkg::FRAC_C) ? mma_pkg::FRAC_C - PROD_FRAC : 0;

    logic signed [PW-1:0]                r_prod;
    logic signed [mma_pkg::DOT_W-1:0]    r_acc;
    logic signed [63:0]                  prod_wide;
    logic signed [mma_pkg::ALIGN_W-1:0]  aligned;
    logic signed [mma_pkg::SUM_W-1:0]    sum;

    // floor shift right or exact left shift, whichever the width calls for
    always_comb begin
        prod_wide = 64'(r_prod);
        aligned   = mma_pkg::ALIGN_W'((prod_wide >>> SH_R) <<< SH_L);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.mul_en) begin
            r_prod <= i_a * i_b;
        end
        if (i_ctrl.clr) begin
            r_acc <= '0;
        end else if (i_ctrl.acc_en) begin
            r_acc <= r_acc + mma_pkg::DOT_W'(aligned);
        end
    end

    always_comb begin
        sum   = mma_pkg::SUM_W'(i_c) + mma_pkg::SUM_W'(r_acc);
        o_sat = (sum[mma_pkg::SUM_W-1] != sum[mma_pkg::C_W-1]);
        if (o_sat) begin
            o_sum = sum[mma_pkg::SUM_W-1] ? {1'b1, {(mma_pkg::C_W-1){1'b0}}}
                                          : {1'b0, {(mma_pkg::C_W-1){1'b1}}};
        end else begin
            o_sum = sum[mma_pkg::C_W-1:0];
        end
    end

endmodule

FILE: src/mma_seq.sv
// ----------------------------------------------------------------------------
// mma_seq: item sequencer
// Decodes input beats, drives the RAM ports, steps the i/j/k loops of a
// compute through the shared MAC unit and owns the output register.
// ----------------------------------------------------------------------------
module mma_seq #(
    parameter int MAX_DIM = 8,
    localparam int DEPTH = MAX_DIM * MAX_DIM,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  mma_pkg::t_in_item              i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output mma_pkg::t_out_item             o_out_data,
    input  mma_pkg::t_dims                 i_dims,
    output logic                           o_a_we,
    output logic [AW-1:0]                  o_a_waddr,
    output logic [AW-1:0]                  o_a_raddr,
    output logic                           o_b_we,
    output logic [AW-1:0]                  o_b_waddr,
    output logic [AW-1:0]                  o_b_raddr,
    output logic                           o_c_we,
    output logic                           o_c_wb,
    output logic [AW-1:0]                  o_c_waddr,
    output logic [AW-1:0]                  o_c_raddr,
    input  logic signed [mma_pkg::C_W-1:0] i_c_q,
    input  logic                           i_mac_sat,
    output mma_pkg::t_mac_ctrl             o_mac_ctrl
);

    function automatic logic [AW-1:0] elem_addr(input logic [mma_pkg::DIM_W-1:0] row,
                                                input logic [mma_pkg::DIM_W-1:0] col);
        int idx;
        idx = int'(row) * MAX_DIM + int'(col);
        return AW'(idx);
    endfunction

    mma_pkg::t_state r_state, n_state;
    logic [mma_pkg::DIM_W-1:0] r_i, n_i, r_j, n_j, r_k, n_k;
    logic r_v1, r_v2, r_drain;
    logic r_ovf, n_ovf;
    logic r_rd_ok, n_rd_ok;
    logic r_res_kind, n_res_kind;
    logic signed [mma_pkg::C_W-1:0] r_res_val, n_res_val;
    logic r_out_valid, n_out_valid;
    mma_pkg::t_out_item r_out_data, n_out_data;

    logic accept;
    logic [mma_pkg::DIM_W-1:0] in_r, in_c;
    mma_pkg::t_state elem_state;

    assign o_in_stall = (r_state != mma_pkg::ST_IDLE) || !i_rst_n;
    assign accept     = i_in_valid && !o_in_stall;
    assign in_r       = {1'b0, i_in_data.row};
    assign in_c       = {1'b0, i_in_data.col};
    assign elem_state = (i_dims.nk == '0) ? mma_pkg::ST_DRAIN : mma_pkg::ST_MAC;

    assign o_a_waddr = elem_addr(in_r, in_c);
    assign o_b_waddr = elem_addr(in_r, in_c);
    assign o_a_raddr = elem_addr(r_i, r_k);
    assign o_b_raddr = elem_addr(r_k, r_j);
    assign o_c_raddr = (r_state == mma_pkg::ST_IDLE) ? elem_addr(in_r, in_c)
                                                     : elem_addr(r_i, r_j);
    assign o_c_waddr = o_c_wb ? elem_addr(r_i, r_j) : elem_addr(in_r, in_c);

    always_comb begin
        n_state     = r_state;
        n_i         = r_i;
        n_j         = r_j;
        n_k         = r_k;
        n_ovf       = r_ovf;
        n_rd_ok     = r_rd_ok;
        n_res_kind  = r_res_kind;
        n_res_val   = r_res_val;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_data  = r_out_data;
        o_a_we      = 1'b0;
        o_b_we      = 1'b0;
        o_c_we      = 1'b0;
        o_c_wb      = 1'b0;
        o_mac_ctrl.clr    = 1'b0;
        o_mac_ctrl.mul_en = r_v1;
        o_mac_ctrl.acc_en = r_v2;

        case (r_state)
            mma_pkg::ST_IDLE: begin
                if (accept) begin
                    case (i_in_data.operation)
                        mma_pkg::OP_WR_A: begin
                            o_a_we = (in_r < i_dims.nr) && (in_c < i_dims.nk);
                        end
                        mma_pkg::OP_WR_B: begin
                            o_b_we = (in_r < i_dims.nk) && (in_c < i_dims.nc);
                        end
                        mma_pkg::OP_WR_C: begin
                            o_c_we = (in_r < i_dims.nr) && (in_c < i_dims.nc);
                        end
                        mma_pkg::OP_COMPUTE: begin
                            n_i = '0;
                            n_j = '0;
                            n_k = '0;
                            o_mac_ctrl.clr = 1'b1;
                            if (i_dims.nr == '0 || i_dims.nc == '0) begin
                                n_res_kind = mma_pkg::KIND_DONE;
                                n_res_val  = '0;
                                n_state    = mma_pkg::ST_RESULT;
                            end else begin
                                n_state = elem_state;
                            end
                        end
                        mma_pkg::OP_READ_C: begin
                            n_rd_ok = (in_r < i_dims.nr) && (in_c < i_dims.nc);
                            n_state = mma_pkg::ST_READ;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            mma_pkg::ST_READ: begin
                n_res_kind = mma_pkg::KIND_READ;
                n_res_val  = r_rd_ok ? i_c_q : '0;
                n_state    = mma_pkg::ST_RESULT;
            end
            mma_pkg::ST_MAC: begin
                if (r_k == i_dims.nk - 4'd1) begin
                    n_state = mma_pkg::ST_DRAIN;
                end else begin
                    n_k = r_k + 4'd1;
                end
            end
            mma_pkg::ST_DRAIN: begin
                // wait for the last product to land and the C read to settle
                if (!r_v1 && !r_v2 && r_drain) begin
                    n_state = mma_pkg::ST_WB;
                end
            end
            mma_pkg::ST_WB: begin
                o_c_we = 1'b1;
                o_c_wb = 1'b1;
                o_mac_ctrl.clr = 1'b1;
                n_k = '0;
                if (i_mac_sat) begin
                    n_ovf = 1'b1;
                end
                if (r_j == i_dims.nc - 4'd1) begin
                    n_j = '0;
                    if (r_i == i_dims.nr - 4'd1) begin
                        n_res_kind = mma_pkg::KIND_DONE;
                        n_res_val  = '0;
                        n_state    = mma_pkg::ST_RESULT;
                    end else begin
                        n_i     = r_i + 4'd1;
                        n_state = elem_state;
                    end
                end else begin
                    n_j     = r_j + 4'd1;
                    n_state = elem_state;
                end
            end
            mma_pkg::ST_RESULT: begin
                // hold until the output register is free
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid           = 1'b1;
                    n_out_data.kind       = r_res_kind;
                    n_out_data.read_value = r_res_val;
                    n_out_data.overflow   = r_ovf;
                    n_state               = mma_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = mma_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mma_pkg::ST_IDLE;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_drain     <= 1'b0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_v1        <= (r_state == mma_pkg::ST_MAC);
            r_v2        <= r_v1;
            r_drain     <= (r_state == mma_pkg::ST_DRAIN);
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i        <= n_i;
        r_j        <= n_j;
        r_k        <= n_k;
        r_rd_ok    <= n_rd_ok;
        r_res_kind <= n_res_kind;
        r_res_val  <= n_res_val;
        r_out_data <= n_out_data;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    a_pipe_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 |-> $past(r_v1))
        else $error("product stage valid without a RAM read beat before it");

    a_ovf_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$fell(r_ovf))
        else $error("overflow flag cleared outside reset");

    a_wb_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mma_pkg::ST_WB) |-> (!r_v1 && !r_v2))
        else $error("C write-back while products are still in flight");

    a_loop_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mma_pkg::ST_MAC) |->
            (r_k < i_dims.nk && r_i < i_dims.nr && r_j < i_dims.nc))
        else $error("loop index outside the set dimensions");

    a_result_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mma_pkg::ST_RESULT && (!r_out_valid || !i_out_stall)) |=>
            (r_out_valid && r_state == mma_pkg::ST_IDLE))
        else $error("result not moved into the output register");

endmodule

FILE: src/matrix_multiply_accumulate_top.sv
// ----------------------------------------------------------------------------
// matrix_multiply_accumulate_top: C += A * B over small on-chip stores
// Channel  | handshake                | beat
// ---------+--------------------------+-------------------------------------
// in       | i_in_valid / o_in_stall  | i_in_data  (mma_pkg::t_in_item)
// out      | o_out_valid / i_out_stall| o_out_data (mma_pkg::t_out_item)
// cfg      | i_cfg_we                 | i_cfg_idx, i_cfg_data
//
// Writes of A, B, C and ignored codes leave the sequencer idle; a read of C
// passes through the READ and RESULT states. A compute steps each element
// through MAC, DRAIN and WB: one shared MAC unit issues one multiply per
// cycle from the A/B RAM read ports, the drain lets the last product land,
// then one C write-back per element. At inner 0 the MAC state is skipped.
// Synchronous active-low reset clears control, the overflow flag and sets
// the dimension registers to 8. A/B/C contents are undefined until written.
// A stalled output beat holds; writes are still taken meanwhile, while a
// read or a compute waits in its last cycle until the output register frees.
// ----------------------------------------------------------------------------
module matrix_multiply_accumulate_top #(
    parameter int MAX_DIM    = 8,
    parameter int ELEM_WIDTH = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  mma_pkg::t_in_item                  i_in_data,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output mma_pkg::t_out_item                 o_out_data,
    input  logic                               i_cfg_we,
    input  logic [mma_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [mma_pkg::CFG_W-1:0]          i_cfg_data
);

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [mma_pkg::CFG_W-1:0] r_rows_a, r_inner_len, r_cols_b;
    mma_pkg::t_dims dims;

    logic a_we, b_we, c_we, c_wb;
    logic [AW-1:0] a_waddr, a_raddr, b_waddr, b_raddr, c_waddr, c_raddr;
    logic [ELEM_WIDTH-1:0] a_q, b_q;
    logic [mma_pkg::C_W-1:0] c_q, c_wdata;
    logic signed [mma_pkg::C_W-1:0] mac_sum;
    logic mac_sat;
    mma_pkg::t_mac_ctrl mac_ctrl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_a    <= mma_pkg::CFG_RESET;
            r_inner_len <= mma_pkg::CFG_RESET;
            r_cols_b    <= mma_pkg::CFG_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                mma_pkg::CFG_ROWS_A:    r_rows_a    <= i_cfg_data;
                mma_pkg::CFG_INNER_LEN: r_inner_len <= i_cfg_data;
                mma_pkg::CFG_COLS_B:    r_cols_b    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // clamp each dimension to the store size
    always_comb begin
        dims.nr = (int'(r_rows_a) > MAX_DIM) ? mma_pkg::DIM_W'(MAX_DIM) : r_rows_a;
        dims.nk = (int'(r_inner_len) > MAX_DIM) ? mma_pkg::DIM_W'(MAX_DIM) : r_inner_len;
        dims.nc = (int'(r_cols_b) > MAX_DIM) ? mma_pkg::DIM_W'(MAX_DIM) : r_cols_b;
    end

    assign c_wdata = c_wb ? mac_sum : i_in_data.value;

    mma_seq #(
        .MAX_DIM(MAX_DIM)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_dims      (dims),
        .o_a_we      (a_we),
        .o_a_waddr   (a_waddr),
        .o_a_raddr   (a_raddr),
        .o_b_we      (b_we),
        .o_b_waddr   (b_waddr),
        .o_b_raddr   (b_raddr),
        .o_c_we      (c_we),
        .o_c_wb      (c_wb),
        .o_c_waddr   (c_waddr),
        .o_c_raddr   (c_raddr),
        .i_c_q       (c_q),
        .i_mac_sat   (mac_sat),
        .o_mac_ctrl  (mac_ctrl)
    );

    mma_ram #(
        .WIDTH(ELEM_WIDTH),
        .DEPTH(DEPTH)
    ) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (a_we),
        .i_waddr (a_waddr),
        .i_wdata (i_in_data.value[ELEM_WIDTH-1:0]),
        .i_raddr (a_raddr),
        .o_rdata (a_q)
    );

    mma_ram #(
        .WIDTH(ELEM_WIDTH),
        .DEPTH(DEPTH)
    ) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (b_we),
        .i_waddr (b_waddr),
        .i_wdata (i_in_data.value[ELEM_WIDTH-1:0]),
        .i_raddr (b_raddr),
        .o_rdata (b_q)
    );

    mma_ram #(
        .WIDTH(mma_pkg::C_W),
        .DEPTH(DEPTH)
    ) u_ram_c (
        .i_clk   (i_clk),
        .i_we    (c_we),
        .i_waddr (c_waddr),
        .i_wdata (c_wdata),
        .i_raddr (c_raddr),
        .o_rdata (c_q)
    );

    mma_mac #(
        .ELEM_WIDTH(ELEM_WIDTH)
    ) u_mac (
        .i_clk  (i_clk),
        .i_ctrl (mac_ctrl),
        .i_a    ($signed(a_q)),
        .i_b    ($signed(b_q)),
        .i_c    ($signed(c_q)),
        .o_sum  (mac_sum),
        .o_sat  (mac_sat)
    );

endmodule
